// ===== sv/dslt_pkg.sv =====
package dslt_pkg;

    // default table depth
    localparam int unsigned DEPTH_DEF = 16;

    // field widths
    localparam int unsigned OP_W     = 3;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_SORTED_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_KEY    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH        = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR         = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // input transaction
    typedef struct packed {
        logic        [OP_W-1:0]  operation;
        logic signed [KEY_W-1:0] key;
    } in_t;

    // result transaction
    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic                       found;
        logic signed [KEY_W-1:0]    front_value;
        logic        [COUNT_W-1:0]  entry_count;
        logic                       is_empty;
    } out_t;

    // control broadcast to every cell
    typedef struct packed {
        logic shift_right;  // open a slot at the first marked cell
        logic shift_left;   // close the slot at the first marked cell
        logic mark_le;      // mark cells holding a value <= key, or unoccupied
        logic mark_eq;      // mark occupied cells equal to key
        logic mark_all;     // mark every cell
    } cell_ctl_t;

endpackage

// ===== sv/dslt_cell.sv =====
module dslt_cell (
    input  logic                                 aclk,
    input  dslt_pkg::cell_ctl_t                  ctl,
    input  logic signed [dslt_pkg::KEY_W-1:0]    key,
    input  logic                                 occ,
    input  logic signed [dslt_pkg::KEY_W-1:0]    left_val,
    input  logic signed [dslt_pkg::KEY_W-1:0]    right_val,
    input  logic                                 chain_in,
    output logic                                 chain_out,
    output logic signed [dslt_pkg::KEY_W-1:0]    value_q,
    output logic signed [dslt_pkg::KEY_W-1:0]    value_next
);

    logic signed [dslt_pkg::KEY_W-1:0] value_reg;
    logic                              mark;

    // local match against the broadcast key
    always_comb begin
        mark = ctl.mark_all
             | (ctl.mark_le & ((value_reg <= key) | ~occ))
             | (ctl.mark_eq & (value_reg == key) & occ);
    end

    // first-match ripple toward the back of the table
    assign chain_out = chain_in | mark;

    // insert takes the key at the first mark and shifts everything behind it;
    // removal pulls from the right neighbor at and behind the first mark
    always_comb begin
        value_next = value_reg;
        if (ctl.shift_right) begin
            if (chain_in) begin
                value_next = left_val;
            end else if (mark) begin
                value_next = key;
            end
        end else if (ctl.shift_left) begin
            if (chain_out) begin
                value_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;

endmodule

// ===== sv/descending_sorted_list_table_top.sv =====
// channel  | ports                       | payload
// ---------+-----------------------------+------------------------------------
// input    | s_valid, s_ready, s_payload | operation, key
// result   | m_valid, m_ready, m_payload | status, found, front_value,
//          |                             | entry_count, is_empty
//
// one transaction per cycle while s_ready is high; its result is registered
// on m_*; per-cell compare and first-match ripple set the clock
// synchronous active-low reset empties the table; stored values keep no reset
// one skid entry behind the result register takes a transaction while m_ready
// is low; s_ready then stays low until m_ready is high at an edge
module descending_sorted_list_table_top #(
    parameter int unsigned DEPTH = dslt_pkg::DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dslt_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output dslt_pkg::out_t   m_payload
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    dslt_pkg::out_t   out_reg, out_next;
    dslt_pkg::out_t   skid_reg, skid_next;
    dslt_pkg::out_t   result;

    dslt_pkg::cell_ctl_t ctl;
    logic                accept;
    logic                pop;
    logic                is_full;
    logic                is_zero;
    logic                hit;
    logic [dslt_pkg::STATUS_W-1:0] status;
    logic                found;

    logic signed [dslt_pkg::KEY_W-1:0] cell_val  [DEPTH];
    logic signed [dslt_pkg::KEY_W-1:0] cell_next [DEPTH];
    logic        [DEPTH:0]             chain;

    assign accept  = s_valid & s_ready;
    assign pop     = m_valid_reg & m_ready;
    assign is_full = (count_reg == CNT_FULL);
    assign is_zero = (count_reg == '0);

    // decode the operation into cell control, status and count update
    always_comb begin
        ctl        = '0;
        status     = dslt_pkg::ST_OK;
        found      = 1'b0;
        count_next = count_reg;
        unique case (s_payload.operation)
            dslt_pkg::OP_SORTED_INSERT: begin
                if (is_full) begin
                    status = dslt_pkg::ST_FULL;
                end else begin
                    ctl.shift_right = accept;
                    ctl.mark_le     = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
            end
            dslt_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    status = dslt_pkg::ST_FULL;
                end else begin
                    ctl.shift_right = accept;
                    ctl.mark_all    = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
            end
            dslt_pkg::OP_REMOVE_KEY: begin
                ctl.mark_eq    = 1'b1;
                ctl.shift_left = accept;
                if (is_zero) begin
                    status = dslt_pkg::ST_EMPTY;
                end else if (!hit) begin
                    status = dslt_pkg::ST_NOT_FOUND;
                end else begin
                    found      = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            dslt_pkg::OP_REMOVE_FRONT: begin
                if (is_zero) begin
                    status = dslt_pkg::ST_EMPTY;
                end else begin
                    ctl.shift_left = accept;
                    ctl.mark_all   = 1'b1;
                    count_next     = count_reg - 1'b1;
                end
            end
            dslt_pkg::OP_SEARCH: begin
                ctl.mark_eq = 1'b1;
                found       = hit;
            end
            dslt_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            count_next = count_reg;
        end
    end

    // row of cells, first-match chain runs from the front
    assign chain[0] = 1'b0;
    assign hit      = chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [dslt_pkg::KEY_W-1:0] left_val;
        logic signed [dslt_pkg::KEY_W-1:0] right_val;
        logic                              occ;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_front
            assign left_val = s_payload.key;
        end else begin : g_mid
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign right_val = s_payload.key;
        end else begin : g_inner
            assign right_val = cell_val[i+1];
        end

        dslt_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .key        (s_payload.key),
            .occ        (occ),
            .left_val   (left_val),
            .right_val  (right_val),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .value_q    (cell_val[i]),
            .value_next (cell_next[i])
        );
    end

    // result for the accepted transaction
    always_comb begin
        result.status      = status;
        result.found       = found;
        result.front_value = (count_next == '0) ? '0 : cell_next[0];
        result.entry_count = dslt_pkg::COUNT_W'(count_next);
        result.is_empty    = (count_next == '0);
    end

    // result register with one skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (accept) begin
            if (m_valid_reg && !m_ready) begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end else begin
                out_next     = result;
                m_valid_next = 1'b1;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_ready   = ~skid_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // count stays within the table depth
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds depth");

    // skid entry is only filled behind a waiting result
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds data without a pending result");

    // an accepted insert into a non-full table grows the count by one
    a_insert_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_full && s_payload.operation == dslt_pkg::OP_SORTED_INSERT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    // a found key always reports ok status
    a_found_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.found) |-> m_payload.status == dslt_pkg::ST_OK)
        else $error("found flagged with error status");

    // empty flag agrees with the reported count
    a_empty_count : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.is_empty == (m_payload.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

endmodule

// ===== verif/descending_sorted_list_table_top_tb.sv =====
module descending_sorted_list_table_top_tb;

    import dslt_pkg::*;

    localparam int unsigned DEPTH        = DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_LIMIT  = 20000;

    // codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    // shadow copy of the list contents
    logic signed [KEY_W-1:0] list_vals [DEPTH];
    int unsigned list_len = 0;

    // predicted results, oldest first
    out_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned op_count       = 0;
    int unsigned directed_count = 0;
    int unsigned full_hits      = 0;
    int unsigned empty_hits     = 0;
    bit          quiet_link     = 1'b0;

    always #5 aclk = ~aclk;

    descending_sorted_list_table_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // drop the entry at pos and pull the tail forward
    function automatic void list_close_gap(int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
        end
        list_len--;
    endfunction

    // apply one operation to the shadow list and build its result
    function automatic out_t apply_list_op(in_t item);
        out_t                    res;
        logic signed [KEY_W-1:0] key;
        int unsigned             pos;
        int unsigned             i;
        bit                      hit;
        res = '0;
        key = $signed(item.key);
        hit = 1'b0;
        pos = 0;
        res.status = ST_OK;
        case (item.operation)
            OP_SORTED_INSERT, OP_PUSH_FRONT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // sorted insert goes ahead of the first entry <= key
                    if (item.operation == OP_SORTED_INSERT) begin
                        while (pos < list_len && !(list_vals[pos] <= key)) pos++;
                    end
                    for (i = list_len; i > pos; i--) begin
                        list_vals[i] = list_vals[i - 1];
                    end
                    list_vals[pos] = key;
                    list_len++;
                end
            end
            OP_REMOVE_KEY: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        if (!hit && list_vals[i] == key) begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                    if (!hit) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        list_close_gap(pos);
                        res.found = 1'b1;
                    end
                end
            end
            OP_REMOVE_FRONT: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_close_gap(0);
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] == key) hit = 1'b1;
                end
                res.found = hit;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.front_value = (list_len > 0) ? list_vals[0] : '0;
        res.entry_count = COUNT_W'(list_len);
        res.is_empty    = (list_len == 0);
        return res;
    endfunction

    // check accepted results, then predict accepted input transactions
    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result: status %0d front %0d count %0d",
                                 m_payload.status, m_payload.front_value,
                                 m_payload.entry_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (m_payload.status !== want.status ||
                        m_payload.found !== want.found ||
                        m_payload.front_value !== want.front_value ||
                        m_payload.entry_count !== want.entry_count ||
                        m_payload.is_empty !== want.is_empty) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"mismatch (exp/got): status %0d/%0d found %0d/%0d",
                                      " front %0d/%0d count %0d/%0d empty %0d/%0d"},
                                     want.status, m_payload.status,
                                     want.found, m_payload.found,
                                     want.front_value, m_payload.front_value,
                                     want.entry_count, m_payload.entry_count,
                                     want.is_empty, m_payload.is_empty);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_list_op(s_payload);
                if (want.status == ST_FULL) full_hits++;
                if (want.status == ST_EMPTY) empty_hits++;
                pending_results.push_back(want);
            end
        end
    end

    // result side: random stall before taking each result
    initial begin : result_sink
        int unsigned stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = quiet_link ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // offer one transaction after a random gap and wait for its accept
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
        int unsigned gap;
        gap = quiet_link ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_payload.operation <= op;
        s_payload.key       <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_SPARE_6 && op != OP_SPARE_7) op_count++;
    endtask

    // remove, search and clear on an empty table
    task automatic test_empty_table();
        send_item(OP_REMOVE_KEY, 32'sd0);
        send_item(OP_REMOVE_FRONT, KEY_MAX);
        send_item(OP_SEARCH, KEY_MIN);
        send_item(OP_CLEAR, -32'sd1);
    endtask

    // fill with extremes and duplicates, then insert and push into a full table
    task automatic test_fill_to_full();
        send_item(OP_SORTED_INSERT, 32'sd0);
        send_item(OP_SORTED_INSERT, KEY_MAX);
        send_item(OP_SORTED_INSERT, KEY_MIN);
        send_item(OP_SORTED_INSERT, -32'sd1);
        send_item(OP_SORTED_INSERT, 32'sd1);
        send_item(OP_SORTED_INSERT, 32'sd5);
        send_item(OP_SORTED_INSERT, 32'sd5);
        send_item(OP_PUSH_FRONT, 32'sd3);
        send_item(OP_SORTED_INSERT, -32'sd100);
        send_item(OP_SORTED_INSERT, 32'sd100);
        send_item(OP_SORTED_INSERT, 32'sd0);
        send_item(OP_SORTED_INSERT, KEY_MAX);
        send_item(OP_SORTED_INSERT, KEY_MIN);
        send_item(OP_PUSH_FRONT, KEY_MIN);
        send_item(OP_SORTED_INSERT, 32'sd42);
        send_item(OP_SORTED_INSERT, -32'sd7);
        send_item(OP_SORTED_INSERT, 32'sd9);
        send_item(OP_PUSH_FRONT, 32'sd9);
    endtask

    // hits and misses on a loaded table, spare codes, clear
    task automatic test_remove_and_search();
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_SEARCH, 32'sd123);
        send_item(OP_REMOVE_KEY, 32'sd5);
        send_item(OP_REMOVE_KEY, 32'sd999);
        send_item(OP_REMOVE_KEY, KEY_MIN);
        send_item(OP_REMOVE_FRONT, 32'sd0);
        send_item(OP_SPARE_6, KEY_MAX);
        send_item(OP_SPARE_7, 32'sd1);
        send_item(OP_CLEAR, 32'sd0);
    endtask

    // keys mostly from a small pool so removes and searches find matches
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            5:       return KEY_MAX;
            6:       return KEY_MIN;
            7, 8, 9: return $signed($urandom);
            default: return $signed($urandom_range(0, 8)) - 32'sd4;
        endcase
    endfunction

    // operation mix leans toward growing or shrinking the table
    function automatic logic [OP_W-1:0] pick_op(bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return (r == 0) ? OP_SPARE_6 : OP_SPARE_7;
        if (r < 6) return OP_CLEAR;
        if (grow) begin
            if (r < 56) return OP_SORTED_INSERT;
            if (r < 70) return OP_PUSH_FRONT;
            if (r < 80) return OP_REMOVE_KEY;
            if (r < 88) return OP_REMOVE_FRONT;
            return OP_SEARCH;
        end
        if (r < 20) return OP_SORTED_INSERT;
        if (r < 26) return OP_PUSH_FRONT;
        if (r < 56) return OP_REMOVE_KEY;
        if (r < 84) return OP_REMOVE_FRONT;
        return OP_SEARCH;
    endfunction

    // alternating fill and drain rounds, some without any idle cycles
    task automatic test_random_traffic();
        int unsigned round;
        int unsigned target;
        int unsigned n;
        round  = 0;
        target = op_count + RANDOM_ITEMS;
        while (op_count < target) begin
            quiet_link = (round % 4 == 3);
            for (n = 0; n < 60; n++) begin
                send_item(pick_op(round[0] == 1'b0), pick_key());
            end
            round++;
        end
        quiet_link = 1'b0;
    endtask

    // reset, tests, drain and verdict
    initial begin : main_seq
        int unsigned guard;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_fill_to_full();
        test_remove_and_search();
        directed_count = op_count;
        test_random_traffic();
        s_valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);

        $display("covered %0d operations (%0d directed) with %0d results checked",
                 op_count, directed_count, checked_count);
        $display("table-full responses %0d, table-empty responses %0d, mismatches %0d",
                 full_hits, empty_hits, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("descending_sorted_list_table_top_tb OK");
        end else begin
            if (pending_results.size() != 0) begin
                $display("%0d results never arrived", pending_results.size());
            end
            $display("descending_sorted_list_table_top_tb NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin : run_limit
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("descending_sorted_list_table_top_tb NOT OK");
        $finish;
    end

endmodule
